// ===== design/tlve_pkg.sv =====
// ----------------------------------------------------------------------------
// tlve_pkg
// Shared types, widths and the vertex order table for the thick line
// vertex expander.
// ----------------------------------------------------------------------------
`default_nettype none

package tlve_pkg;

  // primitive modes
  typedef enum logic [1:0] {
    MODE_LINE = 2'd0,
    MODE_TRI  = 2'd1,
    MODE_QUAD = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  // fixed widths of the normal datapath
  localparam int unsigned NORM_MSB = 19;  // normalised magnitude in [2^19, 2^20)
  localparam int unsigned MAG_W    = 20;  // normalised |nx|, |ny|
  localparam int unsigned SQ_W     = 42;  // a*a + b*b, padded to even width
  localparam int unsigned ROOT_W   = 21;  // floor(sqrt) of the above
  localparam int unsigned REM_W    = 24;  // square root partial remainder
  localparam int unsigned WID_W    = 16;  // line width
  localparam int unsigned PROD_W   = 37;  // c*w + L
  localparam int unsigned DIV_W    = 22;  // divisor 2L
  localparam int unsigned DREM_W   = 23;  // divider partial remainder
  localparam int unsigned QUO_W    = 16;  // offset magnitude
  localparam int unsigned RGBA_W   = 32;
  localparam int unsigned LEAD_W   = 6;   // leading one position
  localparam int unsigned IDX_W    = 3;   // vertex index within a run
  localparam int unsigned NPTS     = 4;   // distinct vertex positions

  // point order: 0 = s-o1, 1 = e-o2, 2 = e+o2, 3 = s+o1
  typedef struct packed {
    logic [1:0] pt;
    logic       last;
  } sel_t;

  function automatic sel_t vtx_sel(mode_e m, logic [IDX_W-1:0] idx);
    sel_t r;
    r.pt   = 2'd0;
    r.last = 1'b0;
    case (m)
      MODE_LINE: begin
        r.pt   = idx[1:0];
        r.last = (idx == 3'd1);
      end
      MODE_TRI: begin
        case (idx)
          3'd0:    r.pt = 2'd0;
          3'd1:    r.pt = 2'd1;
          3'd2:    r.pt = 2'd2;
          3'd3:    r.pt = 2'd0;
          3'd4:    r.pt = 2'd2;
          default: r.pt = 2'd3;
        endcase
        r.last = (idx == 3'd5);
      end
      MODE_QUAD: begin
        r.pt   = idx[1:0];
        r.last = (idx == 3'd3);
      end
      default: begin
        r.pt   = 2'd0;
        r.last = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/tlve_norm.sv =====
// ----------------------------------------------------------------------------
// tlve_norm
// Forms the perpendicular of the segment, takes magnitudes and shifts both
// so that the larger lies in [2^19, 2^20). Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tlve_norm #(
  parameter int unsigned CW = 24,
  parameter int unsigned SW = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic signed [CW-1:0]               sx_i,
  input  wire logic signed [CW-1:0]               sy_i,
  input  wire logic signed [CW-1:0]               ex_i,
  input  wire logic signed [CW-1:0]               ey_i,
  input  wire logic [SW-1:0]                      side_i,
  output logic                                    valid_o,
  output logic [tlve_pkg::MAG_W-1:0]              a_o,
  output logic [tlve_pkg::MAG_W-1:0]              b_o,
  output logic                                    sgnx_o,
  output logic                                    sgny_o,
  output logic                                    zero_o,
  output logic [SW-1:0]                           side_o
);

  localparam int unsigned XW = CW + 1 + tlve_pkg::MAG_W;

  // stage 1: differences and magnitudes
  logic signed [CW:0] nx, ny;
  logic [CW:0]        a1_d, b1_d;
  logic               v1_q, sx1_q, sy1_q;
  logic [CW:0]        a1_q, b1_q;
  logic [SW-1:0]      side1_q;

  assign nx   = {sy_i[CW-1], sy_i} - {ey_i[CW-1], ey_i};
  assign ny   = {ex_i[CW-1], ex_i} - {sx_i[CW-1], sx_i};
  assign a1_d = nx[CW] ? (CW+1)'(-nx) : nx;
  assign b1_d = ny[CW] ? (CW+1)'(-ny) : ny;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= a1_d;
      b1_q    <= b1_d;
      sx1_q   <= nx[CW];
      sy1_q   <= ny[CW];
      side1_q <= side_i;
    end
  end

  // stage 2: leading one of the larger magnitude
  logic [CW:0]                    ab_or;
  logic [tlve_pkg::LEAD_W-1:0]    lead_d;
  logic                           v2_q, sx2_q, sy2_q, z2_q;
  logic [CW:0]                    a2_q, b2_q;
  logic [tlve_pkg::LEAD_W-1:0]    lead2_q;
  logic [SW-1:0]                  side2_q;

  assign ab_or = a1_q | b1_q;

  always_comb begin
    lead_d = '0;
    for (int i = 0; i <= int'(CW); i++) begin
      if (ab_or[i]) lead_d = tlve_pkg::LEAD_W'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q    <= a1_q;
      b2_q    <= b1_q;
      sx2_q   <= sx1_q;
      sy2_q   <= sy1_q;
      z2_q    <= (ab_or == '0);
      lead2_q <= lead_d;
      side2_q <= side1_q;
    end
  end

  // stage 3: shift into the normalised range (right shift truncates)
  localparam logic [tlve_pkg::LEAD_W-1:0] NMSB = tlve_pkg::LEAD_W'(tlve_pkg::NORM_MSB);
  logic [XW-1:0] a_ext, b_ext, a_sh, b_sh;

  assign a_ext = XW'(a2_q);
  assign b_ext = XW'(b2_q);

  always_comb begin
    if (lead2_q > NMSB) begin
      a_sh = a_ext >> (lead2_q - NMSB);
      b_sh = b_ext >> (lead2_q - NMSB);
    end else begin
      a_sh = a_ext << (NMSB - lead2_q);
      b_sh = b_ext << (NMSB - lead2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o    <= a_sh[tlve_pkg::MAG_W-1:0];
      b_o    <= b_sh[tlve_pkg::MAG_W-1:0];
      sgnx_o <= sx2_q;
      sgny_o <= sy2_q;
      zero_o <= z2_q;
      side_o <= side2_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/tlve_sqrt.sv =====
// ----------------------------------------------------------------------------
// tlve_sqrt
// Squares and sums the normalised components, then takes the integer square
// root one result bit per stage (restoring, two radicand bits per step).
// ----------------------------------------------------------------------------
`default_nettype none

module tlve_sqrt #(
  parameter int unsigned SW = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [tlve_pkg::MAG_W-1:0]    a_i,
  input  wire logic [tlve_pkg::MAG_W-1:0]    b_i,
  input  wire logic [SW-1:0]                 side_i,
  output logic                               valid_o,
  output logic [tlve_pkg::ROOT_W-1:0]        root_o,
  output logic [SW-1:0]                      side_o
);

  localparam int unsigned NS  = tlve_pkg::ROOT_W;
  localparam int unsigned SQW = 2 * tlve_pkg::MAG_W;
  localparam int unsigned RW  = tlve_pkg::REM_W;

  // squares
  logic            vm_q;
  logic [SQW-1:0]  sqa_q, sqb_q;
  logic [SW-1:0]   sidem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en_i) begin
      vm_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqa_q   <= a_i * a_i;
      sqb_q   <= b_i * b_i;
      sidem_q <= side_i;
    end
  end

  // root stages: index 0 holds the sum, each further stage one result bit
  logic                            v_q    [NS+1];
  logic [tlve_pkg::SQ_W-1:0]       s_q    [NS+1];
  logic [RW-1:0]                   rm_q   [NS+1];
  logic [tlve_pkg::ROOT_W-1:0]     q_q    [NS+1];
  logic [SW-1:0]                   side_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0]    <= tlve_pkg::SQ_W'(sqa_q) + tlve_pkg::SQ_W'(sqb_q);
      rm_q[0]   <= '0;
      q_q[0]    <= '0;
      side_q[0] <= sidem_q;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [RW-1:0] rm_sh, trial;
    logic          ge;

    assign rm_sh = {rm_q[j][RW-3:0], s_q[j][tlve_pkg::SQ_W-1 -: 2]};
    assign trial = {1'b0, q_q[j], 2'b01};
    assign ge    = (rm_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[j+1]    <= s_q[j] << 2;
        rm_q[j+1]   <= ge ? (rm_sh - trial) : rm_sh;
        q_q[j+1]    <= {q_q[j][tlve_pkg::ROOT_W-2:0], ge};
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign valid_o = v_q[NS];
  assign root_o  = q_q[NS];
  assign side_o  = side_q[NS];

endmodule

`default_nettype wire

// ===== design/tlve_div.sv =====
// ----------------------------------------------------------------------------
// tlve_div
// Four offset magnitudes floor((c*w + L) / (2L)), one product stage, one
// sum stage, then a restoring divider of one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tlve_div #(
  parameter int unsigned SW = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [tlve_pkg::MAG_W-1:0]    c_i   [4],
  input  wire logic [tlve_pkg::WID_W-1:0]    w_i   [4],
  input  wire logic [tlve_pkg::ROOT_W-1:0]   len_i,
  input  wire logic [SW-1:0]                 side_i,
  output logic                               valid_o,
  output logic [tlve_pkg::QUO_W-1:0]         mag_o [4],
  output logic [SW-1:0]                      side_o
);

  localparam int unsigned NQ = tlve_pkg::QUO_W;
  localparam int unsigned PW = tlve_pkg::MAG_W + tlve_pkg::WID_W;
  localparam int unsigned DW = tlve_pkg::DIV_W;
  localparam int unsigned RW = tlve_pkg::DREM_W;

  // products
  logic                         vp_q;
  logic [PW-1:0]                prod_q [4];
  logic [tlve_pkg::ROOT_W-1:0]  lenp_q;
  logic [SW-1:0]                sidep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) prod_q[k] <= c_i[k] * w_i[k];
      lenp_q  <= len_i;
      sidep_q <= side_i;
    end
  end

  // divider stages: index 0 holds the rounded numerator split into
  // remainder head and remaining low bits
  logic                v_q    [NQ+1];
  logic [RW-1:0]       r_q    [NQ+1][4];
  logic [NQ-1:0]       lo_q   [NQ+1][4];
  logic [NQ-1:0]       quo_q  [NQ+1][4];
  logic [DW-1:0]       d_q    [NQ+1];
  logic [SW-1:0]       side_q [NQ+1];

  logic [tlve_pkg::PROD_W-1:0] num [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      num[k] = tlve_pkg::PROD_W'(prod_q[k]) + tlve_pkg::PROD_W'(lenp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        r_q[0][k]   <= RW'(num[k] >> NQ);
        lo_q[0][k]  <= num[k][NQ-1:0];
        quo_q[0][k] <= '0;
      end
      d_q[0]    <= {lenp_q, 1'b0};
      side_q[0] <= sidep_q;
    end
  end

  for (genvar j = 0; j < NQ; j++) begin : g_step
    logic [RW-1:0] r_sh [4];
    logic          ge   [4];

    always_comb begin
      for (int k = 0; k < 4; k++) begin
        r_sh[k] = {r_q[j][k][RW-2:0], lo_q[j][k][NQ-1]};
        ge[k]   = (r_sh[k] >= RW'(d_q[j]));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < 4; k++) begin
          r_q[j+1][k]   <= ge[k] ? (r_sh[k] - RW'(d_q[j])) : r_sh[k];
          lo_q[j+1][k]  <= lo_q[j][k] << 1;
          quo_q[j+1][k] <= {quo_q[j][k][NQ-2:0], ge[k]};
        end
        d_q[j+1]    <= d_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign valid_o = v_q[NQ];
  assign side_o  = side_q[NQ];
  always_comb begin
    for (int k = 0; k < 4; k++) mag_o[k] = quo_q[NQ][k];
  end

endmodule

`default_nettype wire

// ===== design/tlve_emit.sv =====
// ----------------------------------------------------------------------------
// tlve_emit
// Builds the four saturated vertex positions of a segment, drops segments
// with no output, and sends the run of vertices one request at a time.
// Also produces the pipeline advance enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tlve_emit #(
  parameter int unsigned CW = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  output logic                               adv_o,
  input  wire logic                          valid_i,
  input  wire tlve_pkg::mode_e               mode_i,
  input  wire logic signed [CW-1:0]          sx_i,
  input  wire logic signed [CW-1:0]          sy_i,
  input  wire logic signed [CW-1:0]          ex_i,
  input  wire logic signed [CW-1:0]          ey_i,
  input  wire logic                          sgnx_i,
  input  wire logic                          sgny_i,
  input  wire logic                          zero_i,
  input  wire logic [tlve_pkg::QUO_W-1:0]    mag_i [4],
  input  wire logic [tlve_pkg::RGBA_W-1:0]   rgba_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [CW-1:0]               vertex_x_o,
  output logic signed [CW-1:0]               vertex_y_o,
  output logic [tlve_pkg::RGBA_W-1:0]        vertex_rgba_o,
  output logic                               last_vertex_o
);

  localparam int unsigned PW = ((CW > tlve_pkg::QUO_W + 1) ? CW : tlve_pkg::QUO_W + 1) + 1;
  localparam logic signed [PW-1:0] SMAX = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = {{(PW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  function automatic logic [CW-1:0] sat_add(logic signed [CW-1:0] p,
                                            logic signed [PW-1:0] o, logic neg);
    logic signed [PW-1:0] s;
    s = neg ? (PW'(p) - o) : (PW'(p) + o);
    if (s > SMAX)      return SMAX[CW-1:0];
    else if (s < SMIN) return SMIN[CW-1:0];
    else               return s[CW-1:0];
  endfunction

  // signed offsets, zero in line mode so the endpoints pass through
  logic signed [PW-1:0] o1x, o1y, o2x, o2y;
  logic                 is_line, keep;

  assign is_line = (mode_i == tlve_pkg::MODE_LINE);
  assign keep    = valid_i && (mode_i != tlve_pkg::MODE_NONE) && (is_line || !zero_i);

  always_comb begin
    o1x = is_line ? '0 : PW'(mag_i[0]);
    o1y = is_line ? '0 : PW'(mag_i[1]);
    o2x = is_line ? '0 : PW'(mag_i[2]);
    o2y = is_line ? '0 : PW'(mag_i[3]);
    if (sgnx_i) begin
      o1x = -o1x;
      o2x = -o2x;
    end
    if (sgny_i) begin
      o1y = -o1y;
      o2y = -o2y;
    end
  end

  // vertex stage
  logic                   vv_q;
  logic [CW-1:0]          px_q [tlve_pkg::NPTS];
  logic [CW-1:0]          py_q [tlve_pkg::NPTS];
  tlve_pkg::mode_e        vmode_q;
  logic [tlve_pkg::RGBA_W-1:0] vrgba_q;

  // serialiser
  logic                   ser_v_q;
  logic [CW-1:0]          sx_q [tlve_pkg::NPTS];
  logic [CW-1:0]          sy_q [tlve_pkg::NPTS];
  tlve_pkg::mode_e        smode_q;
  logic [tlve_pkg::RGBA_W-1:0] srgba_q;
  logic [tlve_pkg::IDX_W-1:0]  idx_q;
  tlve_pkg::sel_t         sel;
  logic                   ser_free;

  assign sel      = tlve_pkg::vtx_sel(smode_q, idx_q);
  assign ser_free = !ser_v_q || (out_ready_i && sel.last);
  assign adv_o    = !vv_q || ser_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vv_q <= 1'b0;
    end else if (adv_o) begin
      vv_q <= keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      px_q[0] <= sat_add(sx_i, o1x, 1'b1);
      py_q[0] <= sat_add(sy_i, o1y, 1'b1);
      px_q[1] <= sat_add(ex_i, o2x, 1'b1);
      py_q[1] <= sat_add(ey_i, o2y, 1'b1);
      px_q[2] <= sat_add(ex_i, o2x, 1'b0);
      py_q[2] <= sat_add(ey_i, o2y, 1'b0);
      px_q[3] <= sat_add(sx_i, o1x, 1'b0);
      py_q[3] <= sat_add(sy_i, o1y, 1'b0);
      vmode_q <= mode_i;
      vrgba_q <= rgba_i;
    end
  end

  // load a new run when free, otherwise step on each taken request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      idx_q   <= '0;
    end else if (ser_free) begin
      ser_v_q <= vv_q;
      idx_q   <= '0;
    end else if (out_ready_i) begin
      idx_q   <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_free) begin
      sx_q    <= px_q;
      sy_q    <= py_q;
      smode_q <= vmode_q;
      srgba_q <= vrgba_q;
    end
  end

  assign out_valid_o   = ser_v_q;
  assign vertex_x_o    = sx_q[sel.pt];
  assign vertex_y_o    = sy_q[sel.pt];
  assign vertex_rgba_o = srgba_q;
  assign last_vertex_o = sel.last;

  // checks
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 3'd5) else $error("vertex index out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ser_v_q && !out_ready_i) |=> $stable(idx_q))
    else $error("vertex index moved while stalled");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_o |-> (vv_q && ser_v_q)) else $error("pipeline stalled with room");

  a_line_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ser_v_q && smode_q == tlve_pkg::MODE_LINE) |-> idx_q <= 3'd1)
    else $error("line run too long");

endmodule

`default_nettype wire

// ===== design/thick_line_vertex_expander.sv =====
// ----------------------------------------------------------------------------
// thick_line_vertex_expander
// Expands a segment into a run of vertices: endpoints in line mode, a
// widened triangle pair or quad otherwise, with a unit normal scaled by
// half of each end's width.
// ----------------------------------------------------------------------------
// Path from accepted segment to first vertex: normalise, square root, divide,
//   the vertex stage and the output register.
// Throughput: a segment per cycle while in_ready_o is high; the single result
//   port sends a vertex per cycle while out_ready_i is high, 2, 4 or 6 each.
// Reset: asynchronous, active low; clears all valid bits, payload holds.
// ----------------------------------------------------------------------------
`default_nettype none

module thick_line_vertex_expander #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     mode_i,
  input  wire logic signed [COORD_WIDTH-1:0]  start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]  start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]  end_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]  end_y_i,
  input  wire logic [15:0]                    width_start_i,
  input  wire logic [15:0]                    width_end_i,
  input  wire logic [31:0]                    rgba_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [COORD_WIDTH-1:0]       vertex_x_o,
  output logic signed [COORD_WIDTH-1:0]       vertex_y_o,
  output logic [31:0]                         vertex_rgba_o,
  output logic                                last_vertex_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned MW  = tlve_pkg::MAG_W;
  localparam int unsigned SW0 = 2 + 4 * CW + 2 * tlve_pkg::WID_W + tlve_pkg::RGBA_W;
  localparam int unsigned SW1 = SW0 + 2 * MW + 3;

  logic adv;
  assign in_ready_o = adv;

  // normalise
  logic [SW0-1:0] side0_in, side0_n;
  logic           v_n, sgnx_n, sgny_n, zero_n;
  logic [MW-1:0]  a_n, b_n;

  assign side0_in = {mode_i, start_x_i, start_y_i, end_x_i, end_y_i,
                     width_start_i, width_end_i, rgba_i};

  tlve_norm #(.CW(CW), .SW(SW0)) u_norm (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_valid_i),
    .sx_i(start_x_i), .sy_i(start_y_i), .ex_i(end_x_i), .ey_i(end_y_i),
    .side_i(side0_in), .valid_o(v_n), .a_o(a_n), .b_o(b_n),
    .sgnx_o(sgnx_n), .sgny_o(sgny_n), .zero_o(zero_n), .side_o(side0_n)
  );

  // length
  logic [SW1-1:0]              side1_in, side1_s, side1_d;
  logic                        v_s, v_d;
  logic [tlve_pkg::ROOT_W-1:0] len_s;

  assign side1_in = {side0_n, a_n, b_n, sgnx_n, sgny_n, zero_n};

  tlve_sqrt #(.SW(SW1)) u_sqrt (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v_n), .a_i(a_n), .b_i(b_n),
    .side_i(side1_in), .valid_o(v_s), .root_o(len_s), .side_o(side1_s)
  );

  // unpack for the divider
  logic                        m_mode0;
  logic [tlve_pkg::WID_W-1:0]  w1_s, w2_s;
  logic [MW-1:0]               a_s, b_s;
  logic [MW-1:0]               c_s [4];
  logic [tlve_pkg::WID_W-1:0]  w_s [4];

  assign m_mode0 = 1'b0;
  assign w1_s = side1_s[SW1-1-2-4*CW -: tlve_pkg::WID_W];
  assign w2_s = side1_s[SW1-1-2-4*CW-tlve_pkg::WID_W -: tlve_pkg::WID_W];
  assign a_s  = side1_s[3+2*MW-1 -: MW];
  assign b_s  = side1_s[3+MW-1 -: MW];

  always_comb begin
    c_s[0] = a_s;  w_s[0] = w1_s;
    c_s[1] = b_s;  w_s[1] = w1_s;
    c_s[2] = a_s;  w_s[2] = w2_s;
    c_s[3] = b_s;  w_s[3] = w2_s;
  end

  logic [tlve_pkg::QUO_W-1:0] mag_d [4];

  tlve_div #(.SW(SW1)) u_div (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v_s), .c_i(c_s), .w_i(w_s),
    .len_i(len_s), .side_i(side1_s), .valid_o(v_d), .mag_o(mag_d),
    .side_o(side1_d)
  );

  // unpack for vertex build
  tlve_pkg::mode_e              mode_d;
  logic signed [CW-1:0]         sx_d, sy_d, ex_d, ey_d;
  logic [tlve_pkg::RGBA_W-1:0]  rgba_d;

  assign mode_d = tlve_pkg::mode_e'(side1_d[SW1-1 -: 2] | {1'b0, m_mode0});
  assign sx_d   = side1_d[SW1-3 -: CW];
  assign sy_d   = side1_d[SW1-3-CW -: CW];
  assign ex_d   = side1_d[SW1-3-2*CW -: CW];
  assign ey_d   = side1_d[SW1-3-3*CW -: CW];
  assign rgba_d = side1_d[SW1-SW0+tlve_pkg::RGBA_W-1 -: tlve_pkg::RGBA_W];

  tlve_emit #(.CW(CW)) u_emit (
    .clk_i, .rst_ni, .adv_o(adv), .valid_i(v_d), .mode_i(mode_d),
    .sx_i(sx_d), .sy_i(sy_d), .ex_i(ex_d), .ey_i(ey_d),
    .sgnx_i(side1_d[2]), .sgny_i(side1_d[1]), .zero_i(side1_d[0]),
    .mag_i(mag_d), .rgba_i(rgba_d),
    .out_valid_o, .out_ready_i, .vertex_x_o, .vertex_y_o,
    .vertex_rgba_o, .last_vertex_o
  );

endmodule

`default_nettype wire
